// ===== src/assert_macros.svh =====
// Assertion macros shared by the cache modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TLC_ASSERT_SAME(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("cache assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define TLC_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("cache assertion failed");

`endif

// ===== src/tlc_pkg.sv =====
// ----------------------------------------------------------------------------
// tlc_pkg
// Shared types and constants for the two-level write-back cache.
// ----------------------------------------------------------------------------
`default_nettype none

package tlc_pkg;

    localparam int BLOCK_BYTES_DEF  = 64;
    localparam int L1_BYTES_DEF     = 1024;
    localparam int L2_BYTES_DEF     = 2048;
    localparam int MEMORY_BYTES_DEF = 65536;

    localparam int CFG_INDEX_W = 3;
    localparam int COST_W      = 8;
    localparam int ACC_COST_W  = 11;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = 16;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_L1_READ   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_L1_WRITE  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_L2_READ   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_L2_WRITE  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MEM_READ  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MEM_WRITE = 3'd5;

    // Block copy kinds between stores
    typedef enum logic [2:0] {
        CP_NONE,
        CP_L2_MEM,
        CP_MEM_L2,
        CP_L2_FR,
        CP_L1_L2,
        CP_FR_L1
    } copy_t;

    // Cost sources
    typedef enum logic [2:0] {
        CH_NONE,
        CH_L1R,
        CH_L1W,
        CH_L2R,
        CH_L2W,
        CH_MR,
        CH_MW
    } charge_t;

    typedef struct packed {
        logic    load;
        logic    clear;
        logic    sel_vic;
        copy_t   copy;
        charge_t charge;
        logic    cap_l1;
        logic    cap_l2;
        logic    l2_update;
        logic    l2_set_dirty;
        logic    l1_update;
        logic    word_rd;
        logic    word_wr;
        logic    cap_rd;
        logic    add_total;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic l1_hit;
        logic l1_vdirty;
        logic l2_hit;
        logic l2_vdirty;
        logic copy_done;
        logic is_write;
    } status_t;

endpackage

`default_nettype wire

// ===== src/tlc_ram.sv =====
// ----------------------------------------------------------------------------
// tlc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tlc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/tlc_datapath.sv =====
// ----------------------------------------------------------------------------
// tlc_datapath
// Tag arrays, data stores, block copy engine and cost accounting.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tlc_datapath #(
    parameter int BLOCK_BYTES  = 64,
    parameter int L1_BYTES     = 1024,
    parameter int L2_BYTES     = 2048,
    parameter int MEMORY_BYTES = 65536
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire tlc_pkg::cmd_t                      cmd,
    output tlc_pkg::status_t                        status,
    input  wire logic                               cfg_write,
    input  wire logic [tlc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [tlc_pkg::COST_W-1:0]         cfg_data,
    input  wire logic                               kind,
    input  wire logic [tlc_pkg::ADDR_W-1:0]         address,
    input  wire logic [tlc_pkg::DATA_W-1:0]         write_data,
    output logic      [tlc_pkg::DATA_W-1:0]         read_data,
    output logic                                    l1_hit,
    output logic                                    l2_hit,
    output logic      [tlc_pkg::ACC_COST_W-1:0]     access_cost,
    output logic      [tlc_pkg::DATA_W-1:0]         time_total
);
    import tlc_pkg::*;

    localparam int WORDS    = BLOCK_BYTES / 4;
    localparam int WOFF_W   = $clog2(WORDS);
    localparam int OFF_W    = $clog2(BLOCK_BYTES);
    localparam int MEM_AW   = $clog2(MEMORY_BYTES);
    localparam int MA_W     = (MEM_AW < ADDR_W) ? MEM_AW : ADDR_W;
    localparam int BLK_W    = MA_W - OFF_W;
    localparam int L1_LINES = L1_BYTES / BLOCK_BYTES;
    localparam int L2_LINES = L2_BYTES / BLOCK_BYTES;
    localparam int L1I_W    = $clog2(L1_LINES);
    localparam int L2I_W    = $clog2(L2_LINES);
    localparam int L1T_W    = BLK_W - L1I_W;
    localparam int L2T_W    = BLK_W - L2I_W;
    localparam int MW_W     = MA_W - 2;
    localparam int CNT_W    = WOFF_W + 1;

    // Configuration costs
    logic [COST_W-1:0] l1_rd_cost_reg, l1_wr_cost_reg, l2_rd_cost_reg;
    logic [COST_W-1:0] l2_wr_cost_reg, mem_rd_cost_reg, mem_wr_cost_reg;

    // Transaction registers
    logic [MA_W-1:0]       addr_reg;
    logic                  kind_reg;
    logic [DATA_W-1:0]     wdata_reg;
    logic [DATA_W-1:0]     rdata_reg;
    logic                  l1_hit_reg, l2_hit_reg;
    logic [ACC_COST_W-1:0] cost_reg, cost_next;
    logic [DATA_W-1:0]     total_reg;
    logic [COST_W-1:0]     charge_amt;

    // Line state
    logic [L1_LINES-1:0] l1_valid_reg, l1_dirty_reg;
    logic [L1T_W-1:0]    l1_tag_reg [L1_LINES];
    logic [L2_LINES-1:0] l2_valid_reg, l2_dirty_reg;
    logic [L2T_W-1:0]    l2_tag_reg [L2_LINES];

    // Copy and clear counters
    logic [CNT_W-1:0] cnt_reg, wr_cnt;
    logic [MW_W-1:0]  clr_cnt_reg;
    logic             copying;
    logic             copy_done;
    logic             copy_wr;
    logic [WOFF_W-1:0] rd_i, wr_i;

    // Address decode
    logic [L1I_W-1:0]  l1_idx;
    logic [L1T_W-1:0]  l1_tg;
    logic [WOFF_W-1:0] word;
    logic [BLK_W-1:0]  fill_blk, vic_blk, cur_blk, l2v_blk;
    logic [L2I_W-1:0]  l2_idx;
    logic [L2T_W-1:0]  l2_tg;

    // RAM ports
    logic                      l1_we, l2_we, mem_we, fr_we;
    logic [L1I_W+WOFF_W-1:0]   l1_waddr, l1_raddr;
    logic [L2I_W+WOFF_W-1:0]   l2_waddr, l2_raddr;
    logic [MW_W-1:0]           mem_waddr, mem_raddr;
    logic [DATA_W-1:0]         l1_wdata, l2_wdata, mem_wdata;
    logic [DATA_W-1:0]         l1_q, l2_q, mem_q, fr_q;

    assign l1_idx   = addr_reg[OFF_W +: L1I_W];
    assign l1_tg    = addr_reg[MA_W-1 -: L1T_W];
    assign word     = addr_reg[2 +: WOFF_W];
    assign fill_blk = addr_reg[MA_W-1:OFF_W];
    assign vic_blk  = {l1_tag_reg[l1_idx], l1_idx};
    assign cur_blk  = cmd.sel_vic ? vic_blk : fill_blk;
    assign l2_idx   = cur_blk[L2I_W-1:0];
    assign l2_tg    = cur_blk[BLK_W-1:L2I_W];
    assign l2v_blk  = {l2_tag_reg[l2_idx], l2_idx};

    // Status back to the controller
    always_comb
    begin
        status.clear_done = &clr_cnt_reg;
        status.l1_hit     = l1_valid_reg[l1_idx] && (l1_tag_reg[l1_idx] == l1_tg);
        status.l1_vdirty  = l1_valid_reg[l1_idx] && l1_dirty_reg[l1_idx];
        status.l2_hit     = l2_valid_reg[l2_idx] && (l2_tag_reg[l2_idx] == l2_tg);
        status.l2_vdirty  = l2_valid_reg[l2_idx] && l2_dirty_reg[l2_idx];
        status.copy_done  = copy_done;
        status.is_write   = kind_reg;
    end

    // Copy counter: read word cnt, write word cnt-1
    assign copying   = (cmd.copy != CP_NONE);
    assign copy_done = copying && (cnt_reg == CNT_W'(WORDS));
    assign copy_wr   = copying && (cnt_reg != '0);
    assign wr_cnt    = cnt_reg - CNT_W'(1);
    assign rd_i      = cnt_reg[WOFF_W-1:0];
    assign wr_i      = wr_cnt[WOFF_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (!copying || copy_done)
            begin
                cnt_reg <= '0;
            end
            else
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + MW_W'(1);
            end
        end
    end

    // Route RAM ports by copy kind
    always_comb
    begin
        l1_we     = 1'b0;
        l2_we     = 1'b0;
        mem_we    = cmd.clear;
        fr_we     = 1'b0;
        l1_waddr  = {l1_idx, wr_i};
        l1_raddr  = {l1_idx, rd_i};
        l1_wdata  = fr_q;
        l2_waddr  = {l2_idx, wr_i};
        l2_raddr  = {l2_idx, rd_i};
        l2_wdata  = mem_q;
        mem_waddr = cmd.clear ? clr_cnt_reg : {l2v_blk, wr_i};
        mem_raddr = {cur_blk, rd_i};
        mem_wdata = cmd.clear ? '0 : l2_q;
        case (cmd.copy)
            CP_L2_MEM: mem_we = copy_wr;
            CP_MEM_L2: l2_we  = copy_wr;
            CP_L2_FR:  fr_we  = copy_wr;
            CP_L1_L2:
            begin
                l2_we    = copy_wr;
                l2_wdata = l1_q;
            end
            CP_FR_L1:  l1_we  = copy_wr;
            default:   ;
        endcase
        if (cmd.word_rd || cmd.word_wr)
        begin
            l1_raddr = {l1_idx, word};
            l1_waddr = {l1_idx, word};
        end
        if (cmd.word_wr)
        begin
            l1_we    = 1'b1;
            l1_wdata = wdata_reg;
        end
    end

    tlc_ram #(.WIDTH(DATA_W), .DEPTH(L1_LINES * WORDS)) u_l1_ram (
        .clk   (clk),
        .we    (l1_we),
        .waddr (l1_waddr),
        .wdata (l1_wdata),
        .raddr (l1_raddr),
        .rdata (l1_q)
    );

    tlc_ram #(.WIDTH(DATA_W), .DEPTH(L2_LINES * WORDS)) u_l2_ram (
        .clk   (clk),
        .we    (l2_we),
        .waddr (l2_waddr),
        .wdata (l2_wdata),
        .raddr (l2_raddr),
        .rdata (l2_q)
    );

    tlc_ram #(.WIDTH(DATA_W), .DEPTH(2 ** MW_W)) u_mem_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_q)
    );

    tlc_ram #(.WIDTH(DATA_W), .DEPTH(WORDS)) u_fresh_ram (
        .clk   (clk),
        .we    (fr_we),
        .waddr (wr_i),
        .wdata (l2_q),
        .raddr (rd_i),
        .rdata (fr_q)
    );

    // Update line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l1_valid_reg <= '0;
            l1_dirty_reg <= '0;
            l2_valid_reg <= '0;
            l2_dirty_reg <= '0;
        end
        else
        begin
            if (cmd.l1_update)
            begin
                l1_valid_reg[l1_idx] <= 1'b1;
                l1_dirty_reg[l1_idx] <= 1'b0;
            end
            if (cmd.word_wr)
            begin
                l1_dirty_reg[l1_idx] <= 1'b1;
            end
            if (cmd.l2_update)
            begin
                l2_valid_reg[l2_idx] <= 1'b1;
                l2_dirty_reg[l2_idx] <= 1'b0;
            end
            if (cmd.l2_set_dirty)
            begin
                l2_dirty_reg[l2_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.l1_update)
        begin
            l1_tag_reg[l1_idx] <= l1_tg;
        end
        if (cmd.l2_update)
        begin
            l2_tag_reg[l2_idx] <= l2_tg;
        end
    end

    // Write configuration costs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l1_rd_cost_reg  <= COST_W'(1);
            l1_wr_cost_reg  <= COST_W'(1);
            l2_rd_cost_reg  <= COST_W'(10);
            l2_wr_cost_reg  <= COST_W'(10);
            mem_rd_cost_reg <= COST_W'(100);
            mem_wr_cost_reg <= COST_W'(100);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_L1_READ:   l1_rd_cost_reg  <= cfg_data;
                REG_L1_WRITE:  l1_wr_cost_reg  <= cfg_data;
                REG_L2_READ:   l2_rd_cost_reg  <= cfg_data;
                REG_L2_WRITE:  l2_wr_cost_reg  <= cfg_data;
                REG_MEM_READ:  mem_rd_cost_reg <= cfg_data;
                REG_MEM_WRITE: mem_wr_cost_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Select the cost to add
    always_comb
    begin
        case (cmd.charge)
            CH_L1R:  charge_amt = l1_rd_cost_reg;
            CH_L1W:  charge_amt = l1_wr_cost_reg;
            CH_L2R:  charge_amt = l2_rd_cost_reg;
            CH_L2W:  charge_amt = l2_wr_cost_reg;
            CH_MR:   charge_amt = mem_rd_cost_reg;
            CH_MW:   charge_amt = mem_wr_cost_reg;
            default: charge_amt = '0;
        endcase
        cost_next = cost_reg + ACC_COST_W'(charge_amt);
    end

    // Accumulate the running total
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
        end
        else if (cmd.add_total)
        begin
            total_reg <= total_reg + DATA_W'(cost_reg);
        end
    end

    // Capture the transaction, accumulate its cost and capture its results
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            addr_reg   <= address[MA_W-1:0];
            kind_reg   <= kind;
            wdata_reg  <= write_data;
            rdata_reg  <= '0;
            l2_hit_reg <= 1'b0;
            cost_reg   <= '0;
        end
        else
        begin
            cost_reg <= cost_next;
            if (cmd.cap_rd)
            begin
                rdata_reg <= l1_q;
            end
            if (cmd.cap_l2)
            begin
                l2_hit_reg <= status.l2_hit;
            end
        end
        if (cmd.cap_l1)
        begin
            l1_hit_reg <= status.l1_hit;
        end
    end

    assign read_data   = rdata_reg;
    assign l1_hit      = l1_hit_reg;
    assign l2_hit      = l2_hit_reg;
    assign access_cost = cost_reg;
    assign time_total  = total_reg;

    `TLC_ASSERT_NEXT(a_copy_wraps, clk, rst_n, copy_done, cnt_reg == '0)
    `TLC_ASSERT_NEXT(a_l1_fill_hits, clk, rst_n, cmd.l1_update, status.l1_hit)
    `TLC_ASSERT_NEXT(a_l2_fill_hits, clk, rst_n, cmd.l2_update, status.l2_hit)

endmodule

`default_nettype wire

// ===== src/tlc_ctrl.sv =====
// ----------------------------------------------------------------------------
// tlc_ctrl
// Sequencer for the memory clear, lookups, block moves, word access and result handoff.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tlc_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    input  wire tlc_pkg::status_t  status,
    output tlc_pkg::cmd_t          cmd
);
    import tlc_pkg::*;

    typedef enum logic [12:0] {
        S_CLR    = 13'b0000000000001,
        S_IDLE   = 13'b0000000000010,
        S_LOOK   = 13'b0000000000100,
        S_L2CHK  = 13'b0000000001000,
        S_L2WB   = 13'b0000000010000,
        S_MEMRD  = 13'b0000000100000,
        S_L2RD   = 13'b0000001000000,
        S_L1WB   = 13'b0000010000000,
        S_L1FILL = 13'b0000100000000,
        S_WORD   = 13'b0001000000000,
        S_RDWAIT = 13'b0010000000000,
        S_FIN    = 13'b0100000000000,
        S_OUT    = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   vic_reg, vic_next;

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            vic_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            vic_reg   <= vic_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    // Decode next state and commands
    always_comb
    begin
        state_next  = state_reg;
        vic_next    = vic_reg;
        cmd         = '0;
        cmd.sel_vic = vic_reg;
        case (state_reg)
            S_CLR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    vic_next   = 1'b0;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                cmd.cap_l1 = 1'b1;
                state_next = status.l1_hit ? S_WORD : S_L2CHK;
            end
            S_L2CHK:
            begin
                cmd.cap_l2 = !vic_reg;
                if (status.l2_hit)
                begin
                    state_next = vic_reg ? S_L1WB : S_L2RD;
                end
                else
                begin
                    state_next = status.l2_vdirty ? S_L2WB : S_MEMRD;
                end
            end
            S_L2WB:
            begin
                cmd.copy = CP_L2_MEM;
                if (status.copy_done)
                begin
                    cmd.charge = CH_MW;
                    state_next = S_MEMRD;
                end
            end
            S_MEMRD:
            begin
                // the victim block is overwritten whole, so its fetch is only charged
                if (vic_reg)
                begin
                    cmd.charge    = CH_MR;
                    cmd.l2_update = 1'b1;
                    state_next    = S_L1WB;
                end
                else
                begin
                    cmd.copy = CP_MEM_L2;
                    if (status.copy_done)
                    begin
                        cmd.charge    = CH_MR;
                        cmd.l2_update = 1'b1;
                        state_next    = S_L2RD;
                    end
                end
            end
            S_L2RD:
            begin
                cmd.copy = CP_L2_FR;
                if (status.copy_done)
                begin
                    cmd.charge = CH_L2R;
                    if (status.l1_vdirty)
                    begin
                        vic_next   = 1'b1;
                        state_next = S_L2CHK;
                    end
                    else
                    begin
                        state_next = S_L1FILL;
                    end
                end
            end
            S_L1WB:
            begin
                cmd.copy = CP_L1_L2;
                if (status.copy_done)
                begin
                    cmd.charge       = CH_L2W;
                    cmd.l2_set_dirty = 1'b1;
                    state_next       = S_L1FILL;
                end
            end
            S_L1FILL:
            begin
                cmd.copy = CP_FR_L1;
                if (status.copy_done)
                begin
                    cmd.l1_update = 1'b1;
                    state_next    = S_WORD;
                end
            end
            S_WORD:
            begin
                if (status.is_write)
                begin
                    cmd.word_wr = 1'b1;
                    cmd.charge  = CH_L1W;
                end
                else
                begin
                    cmd.word_rd = 1'b1;
                    cmd.charge  = CH_L1R;
                end
                state_next = S_RDWAIT;
            end
            S_RDWAIT:
            begin
                cmd.cap_rd = !status.is_write;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.add_total = 1'b1;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `TLC_ASSERT_NEXT(a_accept_looks, clk, rst_n, state_reg == S_IDLE && in_valid,
        state_reg == S_LOOK)
    `TLC_ASSERT_SAME(a_busy_while_out, clk, rst_n, out_valid, in_stall)

endmodule

`default_nettype wire

// ===== src/two_level_write_back_cache.sv =====
// Sequence: an L1 hit raises out_valid after lookup, word access, read capture and total.
// An L1 miss adds an L2 lookup for the fill and one for a dirty L1 victim, and block moves,
// up to six: L2 victim out, memory fill, L2 to buffer, a second L2 victim out, L1 victim, L1 fill.
// Transactions are taken one at a time: in_stall stays high until the result is handed off.
// Reset: lines go invalid and the backing memory is cleared word by word
// before the first transaction is taken.
// ----------------------------------------------------------------------------
// two_level_write_back_cache
// Direct-mapped write-back L1 and L2 over a word memory with cost accounting.
// ----------------------------------------------------------------------------
`default_nettype none

module two_level_write_back_cache #(
    parameter int BLOCK_BYTES  = tlc_pkg::BLOCK_BYTES_DEF,
    parameter int L1_BYTES     = tlc_pkg::L1_BYTES_DEF,
    parameter int L2_BYTES     = tlc_pkg::L2_BYTES_DEF,
    parameter int MEMORY_BYTES = tlc_pkg::MEMORY_BYTES_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic [tlc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [tlc_pkg::COST_W-1:0]       cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic                             kind,
    input  wire logic [tlc_pkg::ADDR_W-1:0]       address,
    input  wire logic [tlc_pkg::DATA_W-1:0]       write_data,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic      [tlc_pkg::DATA_W-1:0]       read_data,
    output logic                                  l1_hit,
    output logic                                  l2_hit,
    output logic      [tlc_pkg::ACC_COST_W-1:0]   access_cost,
    output logic      [tlc_pkg::DATA_W-1:0]       time_total
);
    import tlc_pkg::*;

    cmd_t    cmd;
    status_t status;

    tlc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    tlc_datapath #(
        .BLOCK_BYTES  (BLOCK_BYTES),
        .L1_BYTES     (L1_BYTES),
        .L2_BYTES     (L2_BYTES),
        .MEMORY_BYTES (MEMORY_BYTES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .kind        (kind),
        .address     (address),
        .write_data  (write_data),
        .read_data   (read_data),
        .l1_hit      (l1_hit),
        .l2_hit      (l2_hit),
        .access_cost (access_cost),
        .time_total  (time_total)
    );

endmodule

`default_nettype wire

// ===== sim/tb_two_level_write_back_cache.sv =====
// ----------------------------------------------------------------------------
// tb_two_level_write_back_cache
// Self-checking bench for the two-level write-back cache. It drives word reads
// and writes with random gaps and stalls on both sides, and keeps its own copy
// of L1, L2, the backing memory and the cost account. Each result is compared
// in order against that copy.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_two_level_write_back_cache;
    timeunit 1ns;
    timeprecision 1ps;

    import tlc_pkg::*;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam int NUM_COSTS = 6;
    localparam int WORDS     = 16;
    localparam int IDLE_LIMIT = 100000;

    typedef struct {
        logic [DATA_W-1:0]     rd;
        logic                  h1;
        logic                  h2;
        logic [ACC_COST_W-1:0] cost;
        logic [DATA_W-1:0]     total;
    } access_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [COST_W-1:0]      cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic                   kind = KIND_READ;
    logic [ADDR_W-1:0]      address = '0;
    logic [DATA_W-1:0]      write_data = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [DATA_W-1:0]      read_data;
    logic                   l1_hit;
    logic                   l2_hit;
    logic [ACC_COST_W-1:0]  access_cost;
    logic [DATA_W-1:0]      time_total;

    two_level_write_back_cache dut (.*);

    always #5 clk = ~clk;

    // Shadow copy of the cache hierarchy
    logic [COST_W-1:0] cost_reg [NUM_COSTS];
    bit          s1_valid [16];
    bit          s1_dirty [16];
    logic [5:0]  s1_tag   [16];
    logic [31:0] s1_words [256];
    bit          s2_valid [32];
    bit          s2_dirty [32];
    logic [4:0]  s2_tag   [32];
    logic [31:0] s2_words [512];
    logic [31:0] mem_words [16384];
    logic [31:0] fill_buf [WORDS];
    logic [31:0] evict_buf [WORDS];
    logic [31:0] mem_buf [WORDS];
    logic [31:0] elapsed;
    logic [31:0] step_cost;

    access_result_t pending_results[$];
    int  errors = 0;
    int  sent = 0;
    int  checked = 0;
    int  l1_hits_seen = 0;
    int  l2_hits_seen = 0;
    bit  quiet = 1'b0;
    int  stall_left = 0;
    int  idle_cycles = 0;

    function automatic void add_cost(input logic [7:0] c);
        elapsed   += 32'(c);
        step_cost += 32'(c);
    endfunction

    // Move one block between L2 and the line buffers; miss fills from memory
    function automatic void l2_block_access(input logic [15:0] a, input bit wr, output bit hit);
        int line;
        int base;
        int vbase;
        logic [4:0] tg;
        line = (a / 64) % 32;
        tg   = 5'(a / 2048);
        hit  = s2_valid[line] && s2_tag[line] == tg;
        if (!hit) begin
            base = (a - a % 64) / 4;
            for (int i = 0; i < WORDS; i++) mem_buf[i] = mem_words[(base + i) % 16384];
            add_cost(cost_reg[REG_MEM_READ]);
            if (s2_valid[line] && s2_dirty[line]) begin
                vbase = ((int'(s2_tag[line]) * 2048) | (line * 64)) / 4;
                for (int i = 0; i < WORDS; i++) mem_words[vbase + i] = s2_words[line*WORDS + i];
                add_cost(cost_reg[REG_MEM_WRITE]);
            end
            for (int i = 0; i < WORDS; i++) s2_words[line*WORDS + i] = mem_buf[i];
            s2_valid[line] = 1'b1;
            s2_tag[line]   = tg;
            s2_dirty[line] = 1'b0;
        end
        if (wr) begin
            for (int i = 0; i < WORDS; i++) s2_words[line*WORDS + i] = evict_buf[i];
            s2_dirty[line] = 1'b1;
            add_cost(cost_reg[REG_L2_WRITE]);
        end else begin
            for (int i = 0; i < WORDS; i++) fill_buf[i] = s2_words[line*WORDS + i];
            add_cost(cost_reg[REG_L2_READ]);
        end
    endfunction

    function automatic access_result_t predict_access(input logic k, input logic [15:0] a,
                                                      input logic [31:0] d);
        access_result_t r;
        int line;
        int wd;
        logic [5:0] tg;
        bit h1;
        bit h2;
        bit unused;
        line = (a / 64) % 16;
        tg   = 6'(a / 1024);
        wd   = (a % 64) / 4;
        h1   = s1_valid[line] && s1_tag[line] == tg;
        h2   = 1'b0;
        step_cost = 0;
        if (!h1) begin
            l2_block_access(a - a % 64, 1'b0, h2);
            if (s1_valid[line] && s1_dirty[line]) begin
                for (int i = 0; i < WORDS; i++) evict_buf[i] = s1_words[line*WORDS + i];
                l2_block_access(16'((int'(s1_tag[line]) * 1024) | (line * 64)), 1'b1, unused);
            end
            for (int i = 0; i < WORDS; i++) s1_words[line*WORDS + i] = fill_buf[i];
            s1_valid[line] = 1'b1;
            s1_tag[line]   = tg;
            s1_dirty[line] = 1'b0;
        end
        r.rd = '0;
        if (k == KIND_WRITE) begin
            s1_words[line*WORDS + wd] = d;
            s1_dirty[line] = 1'b1;
            add_cost(cost_reg[REG_L1_WRITE]);
        end else begin
            r.rd = s1_words[line*WORDS + wd];
            add_cost(cost_reg[REG_L1_READ]);
        end
        r.h1 = h1;
        r.h2 = h2;
        r.cost = step_cost[ACC_COST_W-1:0];
        r.total = elapsed;
        return r;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(99);
        if (quiet || p < 55) return 0;
        if (p < 93) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Send one transaction and record what it must return
    task automatic send_access(input logic k, input logic [15:0] a, input logic [31:0] d);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        in_valid   = 1'b1;
        kind       = k;
        address    = a;
        write_data = d;
        do @(posedge clk); while (in_stall);
        pending_results.push_back(predict_access(k, a, d));
        sent++;
    endtask

    // Drop valid and wait until every result is back
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        wait (pending_results.size() == 0);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_cost(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_write = 1'b0;
        if (int'(idx) < NUM_COSTS) cost_reg[idx] = val;
    endtask

    task automatic write_all_costs(input logic [7:0] v0, input logic [7:0] v1,
                                   input logic [7:0] v2, input logic [7:0] v3,
                                   input logic [7:0] v4, input logic [7:0] v5);
        drain();
        write_cost(REG_L1_READ, v0);
        write_cost(REG_L1_WRITE, v1);
        write_cost(REG_L2_READ, v2);
        write_cost(REG_L2_WRITE, v3);
        write_cost(REG_MEM_READ, v4);
        write_cost(REG_MEM_WRITE, v5);
    endtask

    function automatic logic [15:0] pick_address();
        int p;
        p = $urandom_range(99);
        // hot region: the first four blocks of memory
        if (p < 35) return 16'($urandom_range(255));
        // conflict set: two L1 lines with eight tags each, spread over four L2 lines
        if (p < 80) return 16'(($urandom_range(7) << 10) | ($urandom_range(1) << 6)
                               | $urandom_range(63));
        return 16'($urandom);
    endfunction

    task automatic test_directed();
        send_access(KIND_READ, 16'h0000, 32'h0);
        send_access(KIND_READ, 16'hFFFC, 32'h0);
        send_access(KIND_WRITE, 16'hFFFF, 32'hFFFF_FFFF);
        send_access(KIND_WRITE, 16'h0003, 32'hA5A5_5A5A);
        send_access(KIND_READ, 16'h0000, 32'hFFFF_FFFF);
        send_access(KIND_READ, 16'hFFFC, 32'h0);
        send_access(KIND_WRITE, 16'h0004, 32'h0);
        // dirty victim whose L2 line is the one the fill just replaced
        send_access(KIND_WRITE, 16'h0840, 32'h1234_5678);
        send_access(KIND_READ, 16'h0040, 32'h0);
        send_access(KIND_READ, 16'h0840, 32'h0);
        // chain of dirty L2 victims to memory
        send_access(KIND_WRITE, 16'h1040, 32'h8000_0001);
        send_access(KIND_WRITE, 16'h2040, 32'h7FFF_FFFE);
        send_access(KIND_WRITE, 16'h4040, 32'hDEAD_BEEF);
        send_access(KIND_READ, 16'h8040, 32'h0);
        send_access(KIND_READ, 16'h1040, 32'h0);
        send_access(KIND_READ, 16'h2044, 32'h0);
        send_access(KIND_READ, 16'h4040, 32'h0);
        send_access(KIND_READ, 16'h0842, 32'h0);
    endtask

    task automatic test_cost_extremes();
        int i;
        write_all_costs(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        for (i = 0; i < 20; i++) send_access(logic'($urandom), pick_address(), $urandom);
        write_all_costs(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        for (i = 0; i < 30; i++) send_access(KIND_WRITE, 16'((i % 8) << 11 | 16'h0080), $urandom);
        // out-of-range indexes must leave the costs untouched
        drain();
        write_cost(REG_SPARE_LO, 8'h00);
        write_cost(REG_SPARE_HI, 8'h55);
        for (i = 0; i < 10; i++) send_access(logic'($urandom), pick_address(), $urandom);
    endtask

    task automatic test_random_mix();
        int i;
        for (i = 0; i < 420; i++) begin
            if (i % 140 == 0)
                write_all_costs(8'($urandom), 8'($urandom), 8'($urandom),
                                8'($urandom), 8'($urandom), 8'($urandom));
            quiet = (i >= 280 && i < 330);
            send_access(logic'($urandom), pick_address(), $urandom);
        end
        quiet = 1'b0;
    endtask

    // Receiver stalls: mostly short, a few long
    always @(negedge clk) begin
        if (quiet) begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else begin
            int p;
            p = $urandom_range(99);
            out_stall <= (p >= 60);
            if (p >= 96) stall_left <= $urandom_range(50, 10);
            else if (p >= 60) stall_left <= $urandom_range(2, 0);
        end
    end

    // Compare each result with the oldest expectation
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: read_data %h", read_data);
                errors++;
            end else begin
                access_result_t e;
                e = pending_results.pop_front();
                checked++;
                l1_hits_seen += int'(l1_hit);
                l2_hits_seen += int'(l2_hit);
                if (read_data !== e.rd) begin
                    $error("read_data expected %h actual %h", e.rd, read_data); errors++;
                end
                if (l1_hit !== e.h1) begin
                    $error("l1_hit expected %b actual %b", e.h1, l1_hit); errors++;
                end
                if (l2_hit !== e.h2) begin
                    $error("l2_hit expected %b actual %b", e.h2, l2_hit); errors++;
                end
                if (access_cost !== e.cost) begin
                    $error("access_cost expected %0d actual %0d", e.cost, access_cost);
                    errors++;
                end
                if (time_total !== e.total) begin
                    $error("time_total expected %0d actual %0d", e.total, time_total);
                    errors++;
                end
            end
        end
    end

    // Watchdog: count cycles with no transaction on either side
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL two_level_write_back_cache");
            $finish;
        end
    end

    initial begin
        cost_reg[REG_L1_READ]   = 8'd1;
        cost_reg[REG_L1_WRITE]  = 8'd1;
        cost_reg[REG_L2_READ]   = 8'd10;
        cost_reg[REG_L2_WRITE]  = 8'd10;
        cost_reg[REG_MEM_READ]  = 8'd100;
        cost_reg[REG_MEM_WRITE] = 8'd100;
        for (int i = 0; i < 16; i++) begin
            s1_valid[i] = 0; s1_dirty[i] = 0; s1_tag[i] = '0;
        end
        for (int i = 0; i < 32; i++) begin
            s2_valid[i] = 0; s2_dirty[i] = 0; s2_tag[i] = '0;
        end
        for (int i = 0; i < 256; i++) s1_words[i] = '0;
        for (int i = 0; i < 512; i++) s2_words[i] = '0;
        for (int i = 0; i < 16384; i++) mem_words[i] = '0;
        elapsed = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_cost_extremes();
        test_random_mix();
        drain();

        $display("Covered %0d of %0d accesses (%0d L1 hits, %0d L2 fill hits)",
                 checked, sent, l1_hits_seen, l2_hits_seen);
        $display("under zero, maximum and random cost settings");
        if (errors == 0 && pending_results.size() == 0 && checked == sent)
            $display("PASS two_level_write_back_cache");
        else
            $display("FAIL two_level_write_back_cache");
        $finish;
    end

endmodule

`default_nettype wire
